// ===== sv/htw_pkg.sv =====
package htw_pkg;

    localparam int PTR_W   = 6;
    localparam int DL_W    = 48;
    localparam int REF_W   = 31;
    localparam int TAG_W   = 32;
    localparam int DELAY_W = 16;
    localparam int CNT_W   = 6;

    localparam logic [PTR_W-1:0] EMPTY_PTR = 6'd63;

    typedef enum logic [2:0] {
        CMD_ADD        = 3'd0,
        CMD_EXISTS     = 3'd1,
        CMD_DELETE     = 3'd2,
        CMD_CANCEL_ALL = 3'd3,
        CMD_TICK       = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_ADDED       = 3'd0,
        KIND_EXISTS      = 3'd1,
        KIND_DELETED     = 3'd2,
        KIND_FIRED       = 3'd3,
        KIND_TICK_DONE   = 3'd4,
        KIND_CANCEL_DONE = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DELAY = 2'd1,
        ST_POOL_FULL = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SLOT_WAIT,
        S_SLOT_USE,
        S_WALK,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RP_LOAD,
        RP_MUL,
        RP_SUB,
        RP_FIX
    } t_rem_ph;

    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic [REF_W-1:0]   timer_ref;
        logic [DL_W-1:0]    deadline;
        logic [TAG_W-1:0]   tag;
        logic               found;
        logic [CNT_W-1:0]   live;
        logic               last;
    } t_result;

endpackage

// ===== sv/htw_rem_unit.sv =====
module htw_rem_unit #(
    parameter int WHEEL_SLOTS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [htw_pkg::DL_W-1:0]       i_value,
    output logic                           o_done,
    output logic [$clog2(WHEEL_SLOTS)-1:0] o_rem
);
    import htw_pkg::*;

    localparam int SW    = $clog2(WHEEL_SLOTS);
    localparam int SW1   = SW + 1;
    localparam int DIG_W = 16;
    localparam int NDIG  = DL_W / DIG_W;
    localparam logic [SW:0] MODV  = SW1'(WHEEL_SLOTS);
    localparam logic [31:0] MODW  = 32'(WHEEL_SLOTS);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(WHEEL_SLOTS));

    t_rem_ph          r_ph, n_ph;
    logic             r_busy;
    logic [1:0]       r_dig;
    logic             r_done;
    logic [DL_W-1:0]  r_shift;
    logic [31:0]      r_v;
    logic [15:0]      r_q;
    logic [SW:0]      r_raw;
    logic [SW-1:0]    r_rem;
    logic [63:0]      w_prod;
    logic [31:0]      w_qm;

    // remainder folded in 16-bit digits: quotient estimate by reciprocal,
    // low by at most one, then one compare and subtract
    always_comb begin
        w_prod = {32'b0, r_v} * {32'b0, RECIP};
        w_qm   = 32'(r_q) * MODW;
    end

    always_comb begin
        n_ph = r_ph;
        if (r_busy) begin
            unique case (r_ph)
                RP_LOAD: n_ph = RP_MUL;
                RP_MUL:  n_ph = RP_SUB;
                RP_SUB:  n_ph = RP_FIX;
                RP_FIX:  n_ph = RP_LOAD;
                default: n_ph = RP_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= RP_LOAD;
            r_busy <= 1'b0;
            r_dig  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ph   <= RP_LOAD;
                r_busy <= 1'b1;
                r_dig  <= 2'(NDIG);
            end else if (r_busy) begin
                r_ph <= n_ph;
                if (r_ph == RP_FIX) begin
                    r_dig <= r_dig - 2'd1;
                    if (r_dig == 2'd1) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_rem   <= '0;
        end else if (r_busy) begin
            if (r_ph == RP_LOAD) begin
                r_v     <= {16'(r_rem), r_shift[DL_W-1 -: DIG_W]};
                r_shift <= {r_shift[DL_W-DIG_W-1:0], {DIG_W{1'b0}}};
            end
            if (r_ph == RP_MUL) begin
                r_q <= w_prod[47:32];
            end
            if (r_ph == RP_SUB) begin
                r_raw <= SW1'(r_v - w_qm);
            end
            if (r_ph == RP_FIX) begin
                r_rem <= (r_raw >= MODV) ? SW'(r_raw - MODV) : r_raw[SW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/htw_out_stage.sv =====
module htw_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  htw_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output htw_pkg::t_result o_res
);
    import htw_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/hashed_timer_wheel_unit.sv =====
// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_stall   cmd, delay, user_tag, deadline_in, ref_in
// output   out        o_out_valid / i_out_stall kind, status, timer_ref, deadline_out,
//                                               tag_out, found, live_count, last
// Add passes through accept, slot read, link and result. Exists and delete walk
// the slot's list entry by entry after the slot index comes from a remainder
// unit that folds the deadline in three 16-bit digits, each by load, multiply,
// subtract and fix. Tick reads the due slot and walks every entry of it. After
// reset a clearing pass over all WHEEL_SLOTS slots empties the slot table; no item
// is taken meanwhile. A stalled output holds the sequencer only where a result
// is due.
module hashed_timer_wheel_unit #(
    parameter int WHEEL_SLOTS = 1024,
    parameter int ENTRIES     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_delay,
    input  logic [31:0] i_user_tag,
    input  logic [47:0] i_deadline_in,
    input  logic [30:0] i_ref_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [30:0] o_timer_ref,
    output logic [47:0] o_deadline_out,
    output logic [31:0] o_tag_out,
    output logic        o_found,
    output logic [5:0]  o_live_count,
    output logic        o_last
);
    import htw_pkg::*;

    localparam int SW     = $clog2(WHEEL_SLOTS);
    localparam int SW1    = SW + 1;
    localparam int IW     = $clog2(ENTRIES);
    localparam int SLOT_W = 2 * PTR_W;
    localparam logic [SW:0] MODV = SW1'(WHEEL_SLOTS);

    t_state             r_state, n_state;
    logic [DL_W-1:0]    r_beat, n_beat;
    logic [SW-1:0]      r_beat_slot, n_beat_slot;
    logic [REF_W-1:0]   r_ref_cnt, n_ref_cnt;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [ENTRIES-1:0] r_in_use, n_in_use;
    logic [ENTRIES-1:0] r_cancel, n_cancel;
    logic [SW-1:0]      r_clr, n_clr;
    t_cmd               r_cmd, n_cmd;
    logic [REF_W-1:0]   r_ref_in, n_ref_in;
    logic               r_dl_nz, n_dl_nz;
    logic [SW-1:0]      r_slot, n_slot;
    logic [PTR_W-1:0]   r_new_e, n_new_e;
    logic [PTR_W-1:0]   r_cur, n_cur;
    t_result            r_pend, n_pend;

    logic [SLOT_W-1:0]  r_slot_mem [WHEEL_SLOTS];
    logic [SLOT_W-1:0]  r_slot_rd;
    logic [REF_W-1:0]   r_ent_ref_mem [ENTRIES];
    logic [TAG_W-1:0]   r_ent_tag_mem [ENTRIES];
    logic [PTR_W-1:0]   r_ent_next_mem [ENTRIES];
    logic [REF_W-1:0]   r_rd_ref;
    logic [TAG_W-1:0]   r_rd_tag;
    logic [PTR_W-1:0]   r_rd_next;

    t_cmd               w_in_cmd;
    logic               w_bad_delay;
    logic               w_full;
    logic [PTR_W-1:0]   w_free_e;
    logic [DL_W:0]      w_dl_sum;
    logic [SW:0]        w_slot_sum;
    logic [SW:0]        w_slot_red;
    logic [SW-1:0]      w_add_slot;
    logic [REF_W-1:0]   w_ref_inc;
    logic [REF_W-1:0]   w_ref_new;
    logic [DL_W-1:0]    w_beat_inc;
    logic [SW-1:0]      w_tick_slot;
    logic               w_cur_valid;
    logic [IW-1:0]      w_cur_idx;
    logic [PTR_W-1:0]   w_head;
    logic [PTR_W-1:0]   w_tail;
    logic               w_tail_valid;

    logic               w_slot_we;
    logic [SW-1:0]      w_slot_wa;
    logic [SLOT_W-1:0]  w_slot_wd;
    logic               w_ent_we;
    logic               w_next_we;
    logic [PTR_W-1:0]   w_next_wa;
    logic [PTR_W-1:0]   w_next_wd;
    logic               w_rem_start;
    logic               w_rem_done;
    logic [SW-1:0]      w_rem;
    logic               w_out_load;
    logic               w_out_free;
    t_result            w_out_res;
    t_result            w_out_q;

    assign w_in_cmd    = t_cmd'(i_cmd);
    assign w_bad_delay = (i_delay == '0) || ({16'b0, i_delay} >= 32'(WHEEL_SLOTS));
    assign w_full      = &r_in_use;
    assign w_dl_sum    = {1'b0, r_beat} + {33'b0, i_delay};
    assign w_slot_sum  = {1'b0, r_beat_slot} + SW1'(i_delay);
    assign w_slot_red  = (w_slot_sum >= MODV) ? (w_slot_sum - MODV) : w_slot_sum;
    // on a 48-bit wrap the deadline is below the delay, so it is its own slot
    assign w_add_slot  = w_dl_sum[DL_W] ? w_dl_sum[SW-1:0] : w_slot_red[SW-1:0];
    assign w_ref_inc   = r_ref_cnt + REF_W'(1);
    assign w_ref_new   = (w_ref_inc == '0) ? REF_W'(1) : w_ref_inc;
    assign w_beat_inc  = r_beat + DL_W'(1);
    assign w_tick_slot = (w_beat_inc == '0) ? '0 :
                         (r_beat_slot == SW'(WHEEL_SLOTS - 1)) ? '0 :
                         r_beat_slot + SW'(1);
    assign w_cur_valid  = r_cur < PTR_W'(ENTRIES);
    assign w_cur_idx    = r_cur[IW-1:0];
    assign w_head       = r_slot_rd[SLOT_W-1:PTR_W];
    assign w_tail       = r_slot_rd[PTR_W-1:0];
    assign w_tail_valid = w_tail < PTR_W'(ENTRIES);
    assign o_in_stall   = (r_state != S_IDLE);

    always_comb begin
        w_free_e = EMPTY_PTR;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                w_free_e = PTR_W'(k);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == SW'(WHEEL_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (w_in_cmd) inside
                        CMD_ADD: begin
                            n_state = (w_bad_delay || w_full) ? S_EMIT : S_SLOT_WAIT;
                        end
                        CMD_EXISTS, CMD_DELETE: n_state = S_MOD;
                        CMD_CANCEL_ALL:         n_state = S_EMIT;
                        CMD_TICK:               n_state = S_SLOT_WAIT;
                        default:                n_state = S_IDLE;
                    endcase
                end
            end
            S_MOD: begin
                if (w_rem_done) begin
                    n_state = S_SLOT_WAIT;
                end
            end
            S_SLOT_WAIT: n_state = S_SLOT_USE;
            S_SLOT_USE:  n_state = (r_cmd == CMD_ADD) ? S_EMIT : S_WALK;
            S_WALK: begin
                if (!w_cur_valid) begin
                    n_state = S_EMIT;
                end else if (r_cmd != CMD_TICK && r_rd_ref == r_ref_in) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_beat      = r_beat;
        n_beat_slot = r_beat_slot;
        n_ref_cnt   = r_ref_cnt;
        n_held      = r_held;
        n_in_use    = r_in_use;
        n_cancel    = r_cancel;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_ref_in    = r_ref_in;
        n_dl_nz     = r_dl_nz;
        n_slot      = r_slot;
        n_new_e     = r_new_e;
        n_cur       = r_cur;
        n_pend      = r_pend;
        w_slot_we   = 1'b0;
        w_slot_wa   = r_slot;
        w_slot_wd   = {EMPTY_PTR, EMPTY_PTR};
        w_ent_we    = 1'b0;
        w_next_we   = 1'b0;
        w_next_wa   = w_free_e;
        w_next_wd   = EMPTY_PTR;
        w_rem_start = 1'b0;
        w_out_load  = 1'b0;
        w_out_res   = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_slot_we = 1'b1;
                w_slot_wa = r_clr;
                n_clr     = r_clr + SW'(1);
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = w_in_cmd;
                    n_ref_in = i_ref_in;
                    n_dl_nz  = |i_deadline_in;
                    n_pend   = '0;
                    unique case (w_in_cmd) inside
                        CMD_ADD: begin
                            n_pend.kind = KIND_ADDED;
                            if (w_bad_delay) begin
                                n_pend.status = ST_BAD_DELAY;
                            end else if (w_full) begin
                                n_pend.status = ST_POOL_FULL;
                            end else begin
                                w_ent_we                    = 1'b1;
                                w_next_we                   = 1'b1;
                                n_in_use[w_free_e[IW-1:0]]  = 1'b1;
                                n_cancel[w_free_e[IW-1:0]]  = 1'b0;
                                n_held                      = r_held + CNT_W'(1);
                                n_ref_cnt                   = w_ref_new;
                                n_slot                      = w_add_slot;
                                n_new_e                     = w_free_e;
                                n_pend.timer_ref            = w_ref_new;
                                n_pend.deadline             = w_dl_sum[DL_W-1:0];
                            end
                        end
                        CMD_EXISTS: begin
                            n_pend.kind = KIND_EXISTS;
                            w_rem_start = 1'b1;
                        end
                        CMD_DELETE: begin
                            n_pend.kind = KIND_DELETED;
                            w_rem_start = 1'b1;
                        end
                        CMD_CANCEL_ALL: begin
                            n_pend.kind = KIND_CANCEL_DONE;
                            n_cancel    = r_cancel | r_in_use;
                        end
                        CMD_TICK: begin
                            n_pend.kind = KIND_TICK_DONE;
                            n_beat      = w_beat_inc;
                            n_beat_slot = w_tick_slot;
                            n_slot      = w_tick_slot;
                        end
                        default: begin
                            n_pend = r_pend;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (w_rem_done) begin
                    n_slot = w_rem;
                end
            end
            S_SLOT_WAIT: begin
                n_slot = r_slot;
            end
            S_SLOT_USE: begin
                if (r_cmd == CMD_ADD) begin
                    w_next_we = w_tail_valid;
                    w_next_wa = w_tail;
                    w_next_wd = r_new_e;
                    w_slot_we = 1'b1;
                    w_slot_wd = {(w_tail_valid ? w_head : r_new_e), r_new_e};
                end else begin
                    n_cur     = w_head;
                    w_slot_we = (r_cmd == CMD_TICK);
                end
            end
            S_WALK: begin
                if (r_cmd == CMD_TICK) begin
                    if (w_cur_valid && (r_cancel[w_cur_idx] || w_out_free)) begin
                        n_in_use[w_cur_idx] = 1'b0;
                        if (r_held != '0) begin
                            n_held = r_held - CNT_W'(1);
                        end
                        n_cur = r_rd_next;
                        if (!r_cancel[w_cur_idx]) begin
                            w_out_load     = 1'b1;
                            w_out_res.kind = KIND_FIRED;
                            w_out_res.tag  = r_rd_tag;
                            w_out_res.live = n_held;
                        end
                    end
                end else if (!w_cur_valid) begin
                    if (r_cmd == CMD_DELETE && r_dl_nz) begin
                        n_pend.status = ST_NOT_FOUND;
                    end
                end else if (r_rd_ref == r_ref_in) begin
                    n_pend.found = 1'b1;
                    if (r_cmd == CMD_DELETE) begin
                        n_cancel[w_cur_idx] = 1'b1;
                        n_pend.tag          = r_rd_tag;
                    end
                end else begin
                    n_cur = r_rd_next;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load     = 1'b1;
                    w_out_res      = r_pend;
                    w_out_res.live = r_held;
                    w_out_res.last = 1'b1;
                end
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_beat      <= '0;
            r_beat_slot <= '0;
            r_ref_cnt   <= '0;
            r_held      <= '0;
            r_in_use    <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_beat      <= n_beat;
            r_beat_slot <= n_beat_slot;
            r_ref_cnt   <= n_ref_cnt;
            r_held      <= n_held;
            r_in_use    <= n_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cancel <= n_cancel;
        r_cmd    <= n_cmd;
        r_ref_in <= n_ref_in;
        r_dl_nz  <= n_dl_nz;
        r_slot   <= n_slot;
        r_new_e  <= n_new_e;
        r_cur    <= n_cur;
        r_pend   <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_wa] <= w_slot_wd;
        end
        r_slot_rd <= r_slot_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            r_ent_ref_mem[w_free_e[IW-1:0]] <= w_ref_new;
            r_ent_tag_mem[w_free_e[IW-1:0]] <= i_user_tag;
        end
        if (w_next_we) begin
            r_ent_next_mem[w_next_wa[IW-1:0]] <= w_next_wd;
        end
        r_rd_ref  <= r_ent_ref_mem[n_cur[IW-1:0]];
        r_rd_tag  <= r_ent_tag_mem[n_cur[IW-1:0]];
        r_rd_next <= r_ent_next_mem[n_cur[IW-1:0]];
    end

    htw_rem_unit #(
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_value (i_deadline_in),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    htw_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_out_load),
        .i_res   (w_out_res),
        .i_stall (i_out_stall),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_res   (w_out_q)
    );

    assign o_kind         = w_out_q.kind;
    assign o_status       = w_out_q.status;
    assign o_timer_ref    = w_out_q.timer_ref;
    assign o_deadline_out = w_out_q.deadline;
    assign o_tag_out      = w_out_q.tag;
    assign o_found        = w_out_q.found;
    assign o_live_count   = w_out_q.live;
    assign o_last         = w_out_q.last;

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result during slot clearing");

    a_held_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_use) == int'(r_held))
        else $error("held count differs from entries in use");

    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (w_in_cmd == CMD_ADD || w_in_cmd == CMD_EXISTS
         || w_in_cmd == CMD_DELETE || w_in_cmd == CMD_CANCEL_ALL
         || w_in_cmd == CMD_TICK)) |=> o_in_stall)
        else $error("valid command did not occupy the sequencer");

endmodule
